// File: hdl/awbg_pkg.sv
// ----------------------------------------------------------------------------
// awbg_pkg
// Shared types and constants for the white-balance gain calculation unit.
// ----------------------------------------------------------------------------
package awbg_pkg;

  localparam int RATIO_W   = 16;
  localparam int DVD_W     = 25;            // 512 * 16-bit golden value
  localparam int DIV_STEPS = DVD_W;         // one quotient bit per stage
  localparam int CFG_AW    = 3;

  localparam logic [RATIO_W-1:0] UNITY_GAIN = 16'h0100;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = 16'd512;
  // 256 * 512, numerator of the green gain
  localparam logic [DVD_W-1:0]   GREEN_NUM  = 25'h0020000;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ZERO_OPND  = 2'd1,
    STAT_ZERO_RATIO = 2'd2
  } status_t;

  typedef enum logic {
    REG_GOLDEN_RG = 1'b0,
    REG_GOLDEN_BG = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [RATIO_W-1:0] measured_rg;
    logic [RATIO_W-1:0] measured_bg;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RATIO_W-1:0] red_gain;
    logic [RATIO_W-1:0] green_gain;
    logic [RATIO_W-1:0] blue_gain;
  } out_beat_t;

endpackage

// File: hdl/awbg_div.sv
// ----------------------------------------------------------------------------
// awbg_div
// Pipelined restoring divider, one quotient bit per stage; keeps the low
// 16 quotient bits. Advances only when en is high.
// ----------------------------------------------------------------------------
module awbg_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [awbg_pkg::DVD_W-1:0]   dividend,
  input  logic [awbg_pkg::RATIO_W-1:0] divisor,
  output logic [awbg_pkg::RATIO_W-1:0] quotient
);
  import awbg_pkg::*;

  logic [RATIO_W-1:0] rem_r [DIV_STEPS];
  logic [DVD_W-1:0]   dvd_r [DIV_STEPS];
  logic [RATIO_W-1:0] den_r [DIV_STEPS];
  logic [RATIO_W-1:0] quo_r [DIV_STEPS];

  logic [RATIO_W-1:0] rem_nxt [DIV_STEPS];
  logic [DVD_W-1:0]   dvd_nxt [DIV_STEPS];
  logic [RATIO_W-1:0] quo_nxt [DIV_STEPS];

  logic [RATIO_W-1:0] rem_in [DIV_STEPS];
  logic [DVD_W-1:0]   dvd_in [DIV_STEPS];
  logic [RATIO_W-1:0] den_in [DIV_STEPS];
  logic [RATIO_W-1:0] quo_in [DIV_STEPS];

  always_comb begin
    rem_in[0] = '0;
    dvd_in[0] = dividend;
    den_in[0] = divisor;
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_in[k] = rem_r[k-1];
      dvd_in[k] = dvd_r[k-1];
      den_in[k] = den_r[k-1];
      quo_in[k] = quo_r[k-1];
    end
  end

  always_comb begin
    logic [RATIO_W:0] trial;
    logic             qbit;
    trial = '0;
    qbit  = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_in[k], dvd_in[k][DVD_W-1]};
      qbit  = (trial >= {1'b0, den_in[k]});
      if (qbit) begin
        rem_nxt[k] = RATIO_W'(trial - {1'b0, den_in[k]});
      end else begin
        rem_nxt[k] = trial[RATIO_W-1:0];
      end
      dvd_nxt[k] = {dvd_in[k][DVD_W-2:0], 1'b0};
      quo_nxt[k] = {quo_in[k][RATIO_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvd_r[k] <= dvd_nxt[k];
        den_r[k] <= den_in[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quotient = quo_r[DIV_STEPS-1];

endmodule

// File: hdl/awb_otp_gain_calc_unit.sv
// ----------------------------------------------------------------------------
// awb_otp_gain_calc_unit
// White-balance gains from OTP R/G and B/G ratios against golden ratios.
// ----------------------------------------------------------------------------
// Accepts one ratio pair per cycle. Each result passes through two chained
// 25-stage restoring dividers (ratio stage, then gain stage), one quotient
// bit per stage, and then the output register. The whole pipeline holds
// while a result waits unaccepted at the output.
module awb_otp_gain_calc_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  awbg_pkg::in_beat_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output awbg_pkg::out_beat_t     out_data,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [awbg_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import awbg_pkg::*;

  // configuration
  logic [RATIO_W-1:0] golden_rg_r, golden_bg_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      golden_rg_r <= RATIO_ONE;
      golden_bg_r <= RATIO_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GOLDEN_RG: golden_rg_r <= cfg_pwdata[RATIO_W-1:0];
        REG_GOLDEN_BG: golden_bg_r <= cfg_pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GOLDEN_RG: cfg_prdata = {16'h0, golden_rg_r};
      REG_GOLDEN_BG: cfg_prdata = {16'h0, golden_bg_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic      en;
  logic      in_fire;
  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  logic zero_in;
  assign zero_in = (in_data.measured_rg == '0) || (in_data.measured_bg == '0) ||
                   (golden_rg_r == '0) || (golden_bg_r == '0);

  // ratio stage
  logic [RATIO_W-1:0] r_q, b_q;

  awbg_div u_div_r (
    .clk(clk), .en(en),
    .dividend({golden_rg_r, 9'd0}), .divisor(in_data.measured_rg), .quotient(r_q)
  );
  awbg_div u_div_b (
    .clk(clk), .en(en),
    .dividend({golden_bg_r, 9'd0}), .divisor(in_data.measured_bg), .quotient(b_q)
  );

  logic va_r [DIV_STEPS];
  logic za_r [DIV_STEPS];

  // gain stage
  logic [RATIO_W-1:0] gr_q, gb_q, qbr_q, qrb_q;

  awbg_div u_div_gr (
    .clk(clk), .en(en), .dividend(GREEN_NUM), .divisor(r_q), .quotient(gr_q)
  );
  awbg_div u_div_gb (
    .clk(clk), .en(en), .dividend(GREEN_NUM), .divisor(b_q), .quotient(gb_q)
  );
  awbg_div u_div_br (
    .clk(clk), .en(en), .dividend({1'b0, b_q, 8'd0}), .divisor(r_q), .quotient(qbr_q)
  );
  awbg_div u_div_rb (
    .clk(clk), .en(en), .dividend({1'b0, r_q, 8'd0}), .divisor(b_q), .quotient(qrb_q)
  );

  logic               vb_r [DIV_STEPS];
  logic               zb_r [DIV_STEPS];
  logic [RATIO_W-1:0] rb_r [DIV_STEPS];
  logic [RATIO_W-1:0] bb_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        va_r[k] <= 1'b0;
        vb_r[k] <= 1'b0;
      end
    end else if (en) begin
      va_r[0] <= in_fire;
      vb_r[0] <= va_r[DIV_STEPS-1];
      for (int k = 1; k < DIV_STEPS; k++) begin
        va_r[k] <= va_r[k-1];
        vb_r[k] <= vb_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_r[0] <= zero_in;
      zb_r[0] <= za_r[DIV_STEPS-1];
      rb_r[0] <= r_q;
      bb_r[0] <= b_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        za_r[k] <= za_r[k-1];
        zb_r[k] <= zb_r[k-1];
        rb_r[k] <= rb_r[k-1];
        bb_r[k] <= bb_r[k-1];
      end
    end
  end

  // branch select
  logic [RATIO_W-1:0] r_f, b_f;
  logic               r_ge, b_ge, red_unity, zero_ratio;

  assign r_f  = rb_r[DIV_STEPS-1];
  assign b_f  = bb_r[DIV_STEPS-1];
  assign r_ge = (r_f >= RATIO_ONE);
  assign b_ge = (b_f >= RATIO_ONE);

  always_comb begin
    red_unity  = 1'b0;
    zero_ratio = 1'b0;
    if (r_ge) begin
      zero_ratio = (b_f == '0);
    end else if (b_ge) begin
      red_unity  = 1'b1;
      zero_ratio = (r_f == '0);
    end else if ((r_f == '0) || (b_f == '0)) begin
      zero_ratio = 1'b1;
    end else begin
      red_unity  = (gr_q >= gb_q);
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (zb_r[DIV_STEPS-1]) begin
      out_data_nxt.status = STAT_ZERO_OPND;
    end else if (r_ge && b_ge) begin
      out_data_nxt.status     = STAT_OK;
      out_data_nxt.red_gain   = {1'b0, r_f[RATIO_W-1:1]};
      out_data_nxt.green_gain = UNITY_GAIN;
      out_data_nxt.blue_gain  = {1'b0, b_f[RATIO_W-1:1]};
    end else if (zero_ratio) begin
      out_data_nxt.status = STAT_ZERO_RATIO;
    end else if (red_unity) begin
      out_data_nxt.status     = STAT_OK;
      out_data_nxt.red_gain   = UNITY_GAIN;
      out_data_nxt.green_gain = gr_q;
      out_data_nxt.blue_gain  = qbr_q;
    end else begin
      out_data_nxt.status     = STAT_OK;
      out_data_nxt.red_gain   = qrb_q;
      out_data_nxt.green_gain = gb_q;
      out_data_nxt.blue_gain  = UNITY_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vb_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_fire_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> va_r[0])
    else $error("accepted beat did not enter pipeline");

  a_err_gains_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_OK) |->
      (out_data.red_gain == '0 && out_data.green_gain == '0 && out_data.blue_gain == '0))
    else $error("error beat carries nonzero gain");

  a_ok_has_unity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_OK) |->
      (out_data.red_gain == UNITY_GAIN || out_data.green_gain == UNITY_GAIN ||
       out_data.blue_gain == UNITY_GAIN))
    else $error("no channel at unity gain");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3))
    else $error("illegal status code");

endmodule

// File: tb/tb_awb_otp_gain_calc_unit.sv
// ----------------------------------------------------------------------------
// tb_awb_otp_gain_calc_unit
// Self-checking bench for the white-balance gain unit: drives ratio pairs with
// random gaps, predicts each gain set in-bench, and compares every out beat
// against the oldest prediction. Golden ratios are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_awb_otp_gain_calc_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import awbg_pkg::*;

  localparam int LATENCY   = 51;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  awb_otp_gain_calc_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor's copy of the golden ratios
  logic [15:0] gold_rg = 16'd512;
  logic [15:0] gold_bg = 16'd512;

  in_beat_t  pending_pairs[$];
  out_beat_t expected_gains[$];
  int        err_count = 0;
  bit        quiet_tail = 1'b0;
  int        wdog = 0;

  function automatic out_beat_t predict_gains(in_beat_t p);
    out_beat_t o;
    logic [31:0] r, b, gr, gb;
    bit red_unity;
    o = '0;
    o.status = STAT_OK;
    red_unity = 1'b0;
    if (p.measured_rg == 0 || p.measured_bg == 0 || gold_rg == 0 || gold_bg == 0) begin
      o.status = STAT_ZERO_OPND;
      return o;
    end
    r = ((32'd512 * gold_rg) / p.measured_rg) & 32'hFFFF;
    b = ((32'd512 * gold_bg) / p.measured_bg) & 32'hFFFF;
    if (r >= 512 && b >= 512) begin
      o.red_gain   = 16'((32'd256 * r) / 512);
      o.green_gain = 16'h0100;
      o.blue_gain  = 16'((32'd256 * b) / 512);
      return o;
    end
    if (r >= 512) begin
      if (b == 0) o.status = STAT_ZERO_RATIO;
    end else if (b >= 512) begin
      red_unity = 1'b1;
      if (r == 0) o.status = STAT_ZERO_RATIO;
    end else if (r == 0 || b == 0) begin
      o.status = STAT_ZERO_RATIO;
    end else begin
      gr = (32'd131072 / r) & 32'hFFFF;
      gb = (32'd131072 / b) & 32'hFFFF;
      red_unity = (gr >= gb);
    end
    if (o.status != STAT_OK) return o;
    if (red_unity) begin
      o.red_gain   = 16'h0100;
      o.green_gain = 16'(32'd131072 / r);
      o.blue_gain  = 16'((32'd256 * b) / r);
    end else begin
      o.red_gain   = 16'((32'd256 * r) / b);
      o.green_gain = 16'(32'd131072 / b);
      o.blue_gain  = 16'h0100;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_gains.push_back(predict_gains(in_data));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_data  <= pending_pairs.pop_front();
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result stall
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_gains.size() == 0) begin
          report_mismatch("unexpected beat", out_data.red_gain, 16'h0000);
        end else begin
          out_beat_t e;
          e = expected_gains.pop_front();
          if (out_data.status != e.status)
            report_mismatch("status", 16'(out_data.status), 16'(e.status));
          if (out_data.red_gain != e.red_gain)
            report_mismatch("red_gain", out_data.red_gain, e.red_gain);
          if (out_data.green_gain != e.green_gain)
            report_mismatch("green_gain", out_data.green_gain, e.green_gain);
          if (out_data.blue_gain != e.blue_gain)
            report_mismatch("blue_gain", out_data.blue_gain, e.blue_gain);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // checked on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_pairs.size() > 0 || in_valid || expected_gains.size() > 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(idx));
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_GOLDEN_RG) gold_rg = val;
    else gold_bg = val;
  endtask

  function automatic logic [15:0] rand_ratio();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(65520, 65535));
      2, 3: return 16'($urandom_range(1, 2048));
      4, 5: return 16'($urandom_range(256, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_pair(logic [15:0] rg, logic [15:0] bg);
    in_beat_t p;
    p.measured_rg = rg;
    p.measured_bg = bg;
    pending_pairs.push_back(p);
  endtask

  initial begin
    logic [15:0] gold_set[6][2];
    gold_set = '{'{16'd512, 16'd512}, '{16'd65535, 16'd65535}, '{16'd1, 16'd1},
                 '{16'd0, 16'd700}, '{16'd300, 16'd0}, '{16'd400, 16'd900}};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, each branch, zero operands, zero ratios
    push_pair(16'd512, 16'd512);
    push_pair(16'd256, 16'd256);
    push_pair(16'd256, 16'd1024);
    push_pair(16'd1024, 16'd256);
    push_pair(16'd1024, 16'd700);
    push_pair(16'd700, 16'd1024);
    push_pair(16'd0, 16'd100);
    push_pair(16'd100, 16'd0);
    push_pair(16'd65535, 16'd65535);
    push_pair(16'd1, 16'd1);
    push_pair(16'd1, 16'd65535);
    push_pair(16'd65535, 16'd1);
    push_pair(16'd600, 16'd600);
    push_pair(16'hAAAA, 16'h5555);
    push_pair(16'h5555, 16'hAAAA);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        cfg_write(REG_GOLDEN_RG, gold_set[ph][0]);
        cfg_write(REG_GOLDEN_BG, gold_set[ph][1]);
      end
      if (ph == 5) quiet_tail = 1'b1;
      for (int i = 0; i < 275; i++) push_pair(rand_ratio(), rand_ratio());
      wait_drained();
      repeat (LATENCY + 5) @(posedge clk);
    end
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// File: files.f
hdl/awbg_pkg.sv
hdl/awbg_div.sv
hdl/awb_otp_gain_calc_unit.sv
tb/tb_awb_otp_gain_calc_unit.sv
